FILE: rtl/sha1_pkg.sv
package sha1_pkg;

    // one input word: an optional message byte and the end-of-message mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } msg_item_t;

    // one output word: a slice of the 160-bit digest
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } digest_item_t;

    localparam int unsigned CHAIN_WORDS = 5;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 80;

    // initial chain value
    localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // round constants, one per group of twenty rounds
    localparam logic [31:0] K_GROUP0 = 32'h5A827999;
    localparam logic [31:0] K_GROUP1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_GROUP2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_GROUP3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // block position where the 64-bit length field starts
    localparam logic [5:0] LEN_POS = 6'd56;

endpackage

FILE: rtl/sha1_chan_if.sv
interface sha1_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/sha1_message_digest_core.sv
// channel   dir   payload                                     handshake
// message   in    data_byte[8], has_byte, end_of_message      valid/ready
// digest    out   digest_word[32], word_number[3], last_word  valid/ready
//
// each word is taken while idle; a byte that fills the 64-byte block starts
// the 80 rounds through the single round adder, then the chain add
// end of message: padding and length bytes shift in up to the block end, each
// final block (one or two) runs the rounds and chain add, then five digest words
// message is ready only while idle; digest stalls hold the sequencer in place
// rst_n clears the sequencer and byte count and loads the initial chain value
module sha1_message_digest_core (
    input  logic       clk,
    input  logic       rst_n,
    sha1_chan_if.sink   message,
    sha1_chan_if.source digest
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [6:0] LAST_ROUND = 7'(sha1_pkg::ROUNDS - 1);
    localparam logic [2:0] LAST_WORD  = 3'(sha1_pkg::CHAIN_WORDS - 1);

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] count_reg, count_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        end_pending_reg, end_pending_next;
    logic        marker_done_reg, marker_done_next;
    logic        len_ok_reg, len_ok_next;
    logic        done_reg, done_next;
    logic [31:0] chain_reg [sha1_pkg::CHAIN_WORDS];
    logic [31:0] chain_next [sha1_pkg::CHAIN_WORDS];
    logic [31:0] w_reg [sha1_pkg::BLOCK_WORDS];
    logic [31:0] v_reg [sha1_pkg::CHAIN_WORDS];

    sha1_pkg::msg_item_t    msg;
    sha1_pkg::digest_item_t dig;

    logic        shift_byte;
    logic        round_step;
    logic        load_vars;
    logic [7:0]  byte_in;
    logic        len_now;
    logic [63:0] bit_len;
    logic [5:0]  len_lsb;
    logic [7:0]  len_byte;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] temp;
    logic [31:0] w_new;

    assign msg = message.payload;

    // handshake and output word
    assign message.ready   = (state_reg == ST_IDLE);
    assign digest.valid    = (state_reg == ST_OUT);
    assign dig.digest_word = chain_reg[idx_reg];
    assign dig.word_number = idx_reg;
    assign dig.last_word   = (idx_reg == LAST_WORD);
    assign digest.payload  = dig;

    // length field bytes, most significant first
    assign bit_len  = {count_reg[60:0], 3'b000};
    assign len_lsb  = {~fill_reg[2:0], 3'b000};
    assign len_byte = bit_len[len_lsb +: 8];

    // round function and constant for the current round
    always_comb
    begin
        priority if (rnd_reg < 7'd20)
        begin
            f_val = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            k_val = sha1_pkg::K_GROUP0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = sha1_pkg::K_GROUP1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3]) | (v_reg[2] & v_reg[3]);
            k_val = sha1_pkg::K_GROUP2;
        end
        else
        begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = sha1_pkg::K_GROUP3;
        end
    end

    // shared round adder and schedule expansion
    assign temp  = {v_reg[0][26:0], v_reg[0][31:27]} + f_val + v_reg[4] + k_val + w_reg[0];
    assign w_new = {w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0] ^ w_reg[0][30:0],
                    w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        count_next       = count_reg;
        rnd_next         = rnd_reg;
        idx_next         = idx_reg;
        end_pending_next = end_pending_reg;
        marker_done_next = marker_done_reg;
        len_ok_next      = len_ok_reg;
        done_next        = done_reg;
        chain_next       = chain_reg;
        shift_byte       = 1'b0;
        round_step       = 1'b0;
        load_vars        = 1'b0;
        byte_in          = msg.data_byte;
        len_now          = len_ok_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (message.valid)
                begin
                    end_pending_next = msg.end_of_message;
                    marker_done_next = 1'b0;
                    len_ok_next      = 1'b0;
                    done_next        = 1'b0;
                    if (msg.has_byte)
                    begin
                        shift_byte = 1'b1;
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 64'd1;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = ST_ROUND;
                            rnd_next   = '0;
                            load_vars  = 1'b1;
                        end
                        else if (msg.end_of_message)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                shift_byte = 1'b1;
                fill_next  = fill_reg + 6'd1;
                if (!marker_done_reg)
                begin
                    // marker byte decides whether the length fits in this block
                    byte_in          = sha1_pkg::PAD_MARK;
                    marker_done_next = 1'b1;
                    len_now          = (fill_reg < sha1_pkg::LEN_POS);
                    len_ok_next      = len_now;
                end
                else if (len_ok_reg && (fill_reg >= sha1_pkg::LEN_POS))
                begin
                    byte_in = len_byte;
                end
                else
                begin
                    byte_in = '0;
                end
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = '0;
                    load_vars  = 1'b1;
                    if (len_now)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        len_ok_next = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                round_step = 1'b1;
                rnd_next   = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < sha1_pkg::CHAIN_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                if (done_reg)
                begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end
                else if (end_pending_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (digest.ready)
                begin
                    if (idx_reg == LAST_WORD)
                    begin
                        state_next = ST_IDLE;
                        chain_next = sha1_pkg::H_INIT;
                        count_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, byte count and chain value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_reg        <= '0;
            count_reg       <= '0;
            rnd_reg         <= '0;
            idx_reg         <= '0;
            end_pending_reg <= 1'b0;
            marker_done_reg <= 1'b0;
            len_ok_reg      <= 1'b0;
            done_reg        <= 1'b0;
            chain_reg       <= sha1_pkg::H_INIT;
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            count_reg       <= count_next;
            rnd_reg         <= rnd_next;
            idx_reg         <= idx_next;
            end_pending_reg <= end_pending_next;
            marker_done_reg <= marker_done_next;
            len_ok_reg      <= len_ok_next;
            done_reg        <= done_next;
            chain_reg       <= chain_next;
        end
    end

    // block window: bytes shift in, rounds shift out the schedule
    always_ff @(posedge clk)
    begin
        if (shift_byte)
        begin
            for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++)
            begin
                w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
            end
            w_reg[sha1_pkg::BLOCK_WORDS - 1] <=
                {w_reg[sha1_pkg::BLOCK_WORDS - 1][23:0], byte_in};
        end
        else if (round_step)
        begin
            for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[sha1_pkg::BLOCK_WORDS - 1] <= w_new;
        end
    end

    // working variables a to e
    always_ff @(posedge clk)
    begin
        if (load_vars)
        begin
            v_reg <= chain_reg;
        end
        else if (round_step)
        begin
            v_reg[0] <= temp;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= {v_reg[1][1:0], v_reg[1][31:2]};
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3];
        end
    end

    // digest words appear only on a block boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> (fill_reg == '0))
        else $error("digest shown with a partial block");

    // never take a word while a digest is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(message.ready && digest.valid))
        else $error("input ready while digest pending");

    // the last round is followed by the chain add
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == LAST_ROUND) |=> (state_reg == ST_ADD))
        else $error("round sequence did not end in chain add");

    // after the last digest word the chain and count start over
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && idx_reg == LAST_WORD)
        |=> (chain_reg[0] == sha1_pkg::H_INIT[0] && count_reg == '0
             && state_reg == ST_IDLE))
        else $error("chain not restored after digest");

endmodule
